>>> design/wkc_pkg.sv
// wkc_pkg: shared constants for the five-bit wheel keystream cipher
// wheel lengths, fixed pin patterns and the position wrap functions
// no dependencies

package wkc_pkg;

	localparam int unsigned CODE_W = 5;

	localparam logic [5:0] LEN_CHI1 = 6'd41;
	localparam logic [4:0] LEN_CHI2 = 5'd31;
	localparam logic [4:0] LEN_CHI3 = 5'd29;
	localparam logic [4:0] LEN_CHI4 = 5'd26;
	localparam logic [4:0] LEN_CHI5 = 5'd23;
	localparam logic [5:0] LEN_PSI1 = 6'd43;
	localparam logic [5:0] LEN_PSI2 = 6'd47;
	localparam logic [5:0] LEN_PSI3 = 6'd51;
	localparam logic [5:0] LEN_PSI4 = 6'd53;
	localparam logic [5:0] LEN_PSI5 = 6'd59;
	localparam logic [5:0] LEN_MOT1 = 6'd61;
	localparam logic [5:0] LEN_MOT2 = 6'd37;

	// pin patterns, position zero in the leftmost bit
	localparam logic [0:40] PIN_CHI1 =
		41'b11111_00010_10110_00111_10001_01110_10001_00011_1;
	localparam logic [0:30] PIN_CHI2 =
		31'b11000_01101_01110_11010_11011_00100_0;
	localparam logic [0:28] PIN_CHI3 =
		29'b10001_00111_10011_00011_10111_1010;
	localparam logic [0:25] PIN_CHI4 =
		26'b11110_00110_10001_00011_10100_1;
	localparam logic [0:22] PIN_CHI5 =
		23'b11011_11000_00010_10001_110;
	localparam logic [0:42] PIN_PSI1 =
		43'b10110_00110_10010_10011_01010_10101_01101_01010_100;
	localparam logic [0:46] PIN_PSI2 =
		47'b11010_10101_01010_11101_10101_01010_11000_10101_01011_10;
	localparam logic [0:50] PIN_PSI3 =
		51'b10100_00100_11010_10101_01000_10110_10111_01010_10100_10100_1;
	localparam logic [0:52] PIN_PSI4 =
		53'b01010_11010_10100_00101_01001_10110_10100_11011_01011_01011_001;
	localparam logic [0:58] PIN_PSI5 =
		59'b01010_10101_01010_10110_10100_10011_01010_01001_01010_10010_00100_1010;
	localparam logic [0:60] PIN_MOT1 =
		61'b01011_11110_11010_11001_00011_10111_10001_00100_11100_01111_10101_11010_0;
	localparam logic [0:36] PIN_MOT2 =
		37'b01110_11100_01111_11111_00001_01011_11111_11;

	typedef logic [CODE_W-1:0] code_t;

	function automatic logic [5:0] step6(input logic [5:0] pos, input logic [5:0] len);
		logic [6:0] nxt;
		nxt = {1'b0, pos} + 7'd1;
		step6 = (nxt >= {1'b0, len}) ? 6'd0 : nxt[5:0];
	endfunction

	function automatic logic [4:0] step5(input logic [4:0] pos, input logic [4:0] len);
		logic [5:0] nxt;
		nxt = {1'b0, pos} + 6'd1;
		step5 = (nxt >= {1'b0, len}) ? 5'd0 : nxt[4:0];
	endfunction

endpackage

>>> design/wkc_wheels.sv
// wkc_wheels: chi, psi and motor wheel positions and the key character
// depends on wkc_pkg

module wkc_wheels (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	output wkc_pkg::code_t key
);

	logic [5:0] chi1_q;
	logic [4:0] chi2_q, chi3_q, chi4_q, chi5_q;
	logic [5:0] psi1_q, psi2_q, psi3_q, psi4_q, psi5_q;
	logic [5:0] mot1_q, mot2_q;

	logic [5:0] mot1_nxt, mot2_nxt;
	logic       psi_adv;

	assign key[4] = wkc_pkg::PIN_CHI1[chi1_q] ^ wkc_pkg::PIN_PSI1[psi1_q];
	assign key[3] = wkc_pkg::PIN_CHI2[chi2_q] ^ wkc_pkg::PIN_PSI2[psi2_q];
	assign key[2] = wkc_pkg::PIN_CHI3[chi3_q] ^ wkc_pkg::PIN_PSI3[psi3_q];
	assign key[1] = wkc_pkg::PIN_CHI4[chi4_q] ^ wkc_pkg::PIN_PSI4[psi4_q];
	assign key[0] = wkc_pkg::PIN_CHI5[chi5_q] ^ wkc_pkg::PIN_PSI5[psi5_q];

	// motor chain: mot1 steps, its new pin gates mot2, mot2 pin gates psi
	always_comb begin
		mot1_nxt = wkc_pkg::step6(mot1_q, wkc_pkg::LEN_MOT1);
		mot2_nxt = wkc_pkg::PIN_MOT1[mot1_nxt] ? wkc_pkg::step6(mot2_q, wkc_pkg::LEN_MOT2)
			: mot2_q;
		psi_adv  = wkc_pkg::PIN_MOT2[mot2_nxt];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chi1_q <= '0;
			chi2_q <= '0;
			chi3_q <= '0;
			chi4_q <= '0;
			chi5_q <= '0;
			psi1_q <= '0;
			psi2_q <= '0;
			psi3_q <= '0;
			psi4_q <= '0;
			psi5_q <= '0;
			mot1_q <= '0;
			mot2_q <= '0;
		end else if (step) begin
			chi1_q <= wkc_pkg::step6(chi1_q, wkc_pkg::LEN_CHI1);
			chi2_q <= wkc_pkg::step5(chi2_q, wkc_pkg::LEN_CHI2);
			chi3_q <= wkc_pkg::step5(chi3_q, wkc_pkg::LEN_CHI3);
			chi4_q <= wkc_pkg::step5(chi4_q, wkc_pkg::LEN_CHI4);
			chi5_q <= wkc_pkg::step5(chi5_q, wkc_pkg::LEN_CHI5);
			mot1_q <= mot1_nxt;
			mot2_q <= mot2_nxt;
			if (psi_adv) begin
				psi1_q <= wkc_pkg::step6(psi1_q, wkc_pkg::LEN_PSI1);
				psi2_q <= wkc_pkg::step6(psi2_q, wkc_pkg::LEN_PSI2);
				psi3_q <= wkc_pkg::step6(psi3_q, wkc_pkg::LEN_PSI3);
				psi4_q <= wkc_pkg::step6(psi4_q, wkc_pkg::LEN_PSI4);
				psi5_q <= wkc_pkg::step6(psi5_q, wkc_pkg::LEN_PSI5);
			end
		end
	end

	a_chi1_range: assert property (@(posedge clk) disable iff (!arst_n)
		chi1_q < wkc_pkg::LEN_CHI1) else $error("chi1 position out of range");

	a_mot_range: assert property (@(posedge clk) disable iff (!arst_n)
		mot1_q < wkc_pkg::LEN_MOT1 && mot2_q < wkc_pkg::LEN_MOT2)
		else $error("motor position out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(chi1_q) && $stable(mot1_q) && $stable(psi1_q))
		else $error("wheels moved without a word");

	a_chi_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> chi5_q == wkc_pkg::step5($past(chi5_q), wkc_pkg::LEN_CHI5))
		else $error("chi5 did not step");

	a_psi_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> ($stable(psi1_q) == $stable(psi5_q)))
		else $error("psi wheels out of lockstep");

endmodule

>>> design/wheel_keystream_cipher_5bit.sv
// wheel_keystream_cipher_5bit: top level, input register, key mix and result register
// depends on wkc_pkg and wkc_wheels

// Each word carries one five-bit teleprinter code and comes back as the code XORed
// with a key character built from ten pinwheels, together with that key. The block
// takes one word per cycle while the output side is ready: a word waits in the input
// register, and as it moves to the result register the key is mixed in and the wheels
// step; while the output side stalls the word stays in the input register.
// The wheel step path (motor wrap, pin lookup, second motor, pin lookup) sets the
// cycle time. All wheel positions return to zero on reset.

module wheel_keystream_cipher_5bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // code_in[4:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // code_out[4:0], key_used[9:5], zero pad
);

	logic           valid_s1;
	wkc_pkg::code_t code_s1;
	logic           out_valid_q;
	wkc_pkg::code_t code_out_q;
	wkc_pkg::code_t key_out_q;
	wkc_pkg::code_t key;
	logic           out_free;
	logic           move;

	assign out_free = !out_valid_q || m_tready;
	assign move     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	wkc_wheels u_wheels (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (move),
		.key    (key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= s_tdata[4:0];
		end
		if (move) begin
			code_out_q <= code_s1 ^ key;
			key_out_q  <= key;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, key_out_q, code_out_q};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready) else $error("input stalled while empty");

	a_move_fills: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q) else $error("word lost on the way out");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(code_s1))
		else $error("input stage changed while stalled");

	a_out_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (code_out_q ^ key_out_q) == $past(code_s1, 1) || !$past(move))
		else $error("result does not match its input");

endmodule
